/* rtl/assert_macros.svh */
// Assertion helpers for the RTL, included by i2cbm_core. Defining NO_ASSERTIONS compiles them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/i2cbm_pkg.sv */
`timescale 1ns / 1ps

package i2cbm_pkg;

	// Bus commands, encoded as on the opcode field.
	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_STOP    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_READ    = 3'd3,
		CMD_WAITACK = 3'd4
	} cmd_t;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
	localparam logic [3:0] BIT_LAST        = 4'd7;
	localparam logic [3:0] BIT_COUNT       = 4'd8;
	localparam logic [2:0] PHASE_LAST      = 3'd2;
	localparam logic [2:0] PHASE_COUNT     = 3'd3;

	// One tick as it enters the block.
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       ack_after_read;
		logic       sda_in;
	} tick_t;

	// One result word, produced for every tick.
	typedef struct packed {
		logic       nack_seen;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       ready_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

endpackage

/* rtl/i2c_bit_level_master.sv */
`timescale 1ns / 1ps
// I2C bit-level master sequencer, clocked by time ticks on a stream.
// Each input word is one bus tick: tdata carries the byte to send, the ACK choice
// for a read and the sampled SDA level; tuser carries the command strobe and the
// opcode (start, stop, write byte, read byte, wait for acknowledge). A command is
// honoured only when the block is idle; otherwise it is ignored and the tick just
// advances the current bus phase, each phase lasting phase_ticks ticks.
// Every input word produces exactly one output word with the SCL and SDA levels,
// the ready flag, a done pulse, the last received byte and the last ACK result.
// An input word passes through the input register, then the sequencer logic
// feeding the output register. Throughput is one word per cycle while the output
// side does not stall; the sequencer state advances once per word.
// Reset (arst_n low) releases both lines, returns to idle and sets phase_ticks
// to four. When the output side stalls, the output register holds its word, the
// input register fills and tready drops until the output word is taken. The user
// writes phase_ticks through cfg_we/cfg_wdata only while the block is idle; unchecked.

module i2c_bit_level_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,       // phase_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // tx_byte[7:0], ack_after_read, sda_in, zero pad
	input  logic [3:0]  s_axis_tuser,    // cmd_valid, opcode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata     // scl_out, sda_out, ready_res, done_res,
	                                     // rx_byte[7:0], nack_seen, zero pad
);

	i2cbm_pkg::tick_t in_tick;
	i2cbm_pkg::tick_t tick_s1;
	i2cbm_pkg::res_t  res_d;
	i2cbm_pkg::res_t  res_s2;
	logic             valid_s1;
	logic             can_load;
	logic             step_en;

	assign in_tick.cmd_valid      = s_axis_tuser[0];
	assign in_tick.opcode         = s_axis_tuser[3:1];
	assign in_tick.tx_byte        = s_axis_tdata[7:0];
	assign in_tick.ack_after_read = s_axis_tdata[8];
	assign in_tick.sda_in         = s_axis_tdata[9];

	// The sequencer steps whenever a tick is held and the output register can take
	// its result.
	assign step_en = valid_s1 && can_load;

	i2cbm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_tick  (in_tick),
		.take     (can_load),
		.valid_s1 (valid_s1),
		.tick_s1  (tick_s1)
	);

	i2cbm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_en   (step_en),
		.tick_s1   (tick_s1),
		.res_d     (res_d)
	);

	i2cbm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_en),
		.res_d     (res_d),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_s2    (res_s2)
	);

	assign m_axis_tdata = {3'b000, res_s2};

endmodule

/* rtl/i2cbm_in_stage.sv */
`timescale 1ns / 1ps

module i2cbm_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2cbm_pkg::tick_t   in_tick,
	input  logic               take,
	output logic               valid_s1,
	output i2cbm_pkg::tick_t   tick_s1
);

	logic load;

	// The slot frees up in the same cycle its word moves on.
	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tick_s1 <= in_tick;
		end
	end

endmodule

/* rtl/i2cbm_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cbm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               step_en,
	input  i2cbm_pkg::tick_t   tick_s1,
	output i2cbm_pkg::res_t    res_d
);

	typedef struct packed {
		logic scl;
		logic sda;
	} lines_t;

	i2cbm_pkg::cmd_t cmd_q, cmd_d;
	logic       busy_q, busy_d;
	logic [2:0] step_q, step_d;
	logic [7:0] tick_q, tick_d;
	logic [3:0] bit_idx_q, bit_idx_d;
	logic [7:0] shift_q, shift_d;
	lines_t     lines_q, lines_d;
	logic [7:0] rx_q, rx_d;
	logic       ack_q, ack_d;
	logic       ackp_q, ackp_d;
	logic       done_d;
	logic [7:0] phase_ticks_q;

	// Line levels set on entering a phase.
	function automatic lines_t enter_phase(
		input i2cbm_pkg::cmd_t cmd,
		input logic [2:0]      step,
		input logic [3:0]      bit_idx,
		input logic [7:0]      shift,
		input logic            ackp,
		input lines_t          cur
	);
		lines_t l;
		l = cur;
		case (cmd)
			i2cbm_pkg::CMD_START: begin
				if (step == 3'd0) begin
					l.sda = 1'b1;
					l.scl = 1'b1;
				end else if (step == 3'd1) begin
					l.sda = 1'b0;
				end else begin
					l.scl = 1'b0;
				end
			end
			i2cbm_pkg::CMD_STOP: begin
				l.sda = 1'b0;
				l.scl = 1'b1;
			end
			i2cbm_pkg::CMD_WRITE: begin
				if (step == 3'd0) begin
					l.sda = shift[7];
				end else if (step == 3'd1) begin
					l.scl = 1'b1;
				end else begin
					l.scl = 1'b0;
					if (bit_idx == i2cbm_pkg::BIT_LAST) begin
						l.sda = 1'b1;
					end
				end
			end
			i2cbm_pkg::CMD_READ: begin
				if (bit_idx < i2cbm_pkg::BIT_COUNT) begin
					l.scl = (step == 3'd0);
				end else if (step == 3'd0) begin
					l.sda = !ackp;
				end else if (step == 3'd1) begin
					l.scl = 1'b1;
				end else begin
					l.scl = 1'b0;
				end
			end
			default: begin
				// Wait for acknowledge.
				if (step == 3'd0) begin
					l.sda = 1'b1;
				end else if (step == 3'd1) begin
					l.scl = 1'b1;
				end else begin
					l.scl = 1'b0;
				end
			end
		endcase
		return l;
	endfunction

	// Next state for one tick.
	always_comb begin
		logic finish;
		logic phase_end;
		finish    = 1'b0;
		phase_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, phase_ticks_q};
		cmd_d     = cmd_q;
		busy_d    = busy_q;
		step_d    = step_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		lines_d   = lines_q;
		rx_d      = rx_q;
		ack_d     = ack_q;
		ackp_d    = ackp_q;
		done_d    = 1'b0;

		if (busy_q) begin
			if (phase_end) begin
				tick_d = 8'd0;
				case (cmd_q)
					i2cbm_pkg::CMD_START: begin
						step_d = step_q + 3'd1;
						finish = (step_d >= i2cbm_pkg::PHASE_COUNT);
					end
					i2cbm_pkg::CMD_STOP: begin
						lines_d.sda = 1'b1;
						finish      = 1'b1;
					end
					i2cbm_pkg::CMD_WRITE: begin
						if (step_q < i2cbm_pkg::PHASE_LAST) begin
							step_d = step_q + 3'd1;
						end else begin
							step_d    = 3'd0;
							shift_d   = {shift_q[6:0], 1'b0};
							bit_idx_d = bit_idx_q + 4'd1;
							finish    = (bit_idx_d >= i2cbm_pkg::BIT_COUNT);
						end
					end
					i2cbm_pkg::CMD_READ: begin
						if (bit_idx_q < i2cbm_pkg::BIT_COUNT) begin
							if (step_q == 3'd0) begin
								shift_d = {shift_q[6:0], tick_s1.sda_in};
								step_d  = 3'd1;
							end else begin
								step_d    = 3'd0;
								bit_idx_d = bit_idx_q + 4'd1;
								if (bit_idx_d == i2cbm_pkg::BIT_COUNT) begin
									rx_d = shift_q;
								end
							end
						end else begin
							step_d = step_q + 3'd1;
							if (step_d >= i2cbm_pkg::PHASE_COUNT) begin
								lines_d.sda = 1'b1;
								finish      = 1'b1;
							end
						end
					end
					default: begin
						if (step_q == 3'd1) begin
							ack_d = tick_s1.sda_in;
						end
						step_d = step_q + 3'd1;
						finish = (step_d >= i2cbm_pkg::PHASE_COUNT);
					end
				endcase
				if (finish) begin
					busy_d = 1'b0;
					done_d = 1'b1;
				end else begin
					lines_d = enter_phase(cmd_d, step_d, bit_idx_d, shift_d, ackp_d, lines_d);
				end
			end else begin
				tick_d = tick_q + 8'd1;
			end
		end else if (tick_s1.cmd_valid && (tick_s1.opcode <= 3'(i2cbm_pkg::CMD_WAITACK))) begin
			cmd_d     = i2cbm_pkg::cmd_t'(tick_s1.opcode);
			busy_d    = 1'b1;
			step_d    = 3'd0;
			tick_d    = 8'd0;
			bit_idx_d = 4'd0;
			if (cmd_d == i2cbm_pkg::CMD_WRITE) begin
				shift_d = tick_s1.tx_byte;
			end else if (cmd_d == i2cbm_pkg::CMD_READ) begin
				shift_d = 8'd0;
				ackp_d  = tick_s1.ack_after_read;
			end
			lines_d = enter_phase(cmd_d, step_d, bit_idx_d, shift_d, ackp_d, lines_d);
		end
	end

	// Result word, taken from the state after this tick.
	always_comb begin
		res_d.scl_out   = lines_d.scl;
		res_d.sda_out   = lines_d.sda;
		res_d.ready_res = !busy_d;
		res_d.done_res  = done_d;
		res_d.rx_byte   = rx_d;
		res_d.nack_seen = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cbm_pkg::PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= i2cbm_pkg::CMD_START;
			busy_q    <= 1'b0;
			step_q    <= 3'd0;
			tick_q    <= 8'd0;
			bit_idx_q <= 4'd0;
			shift_q   <= 8'd0;
			lines_q   <= '{scl: 1'b1, sda: 1'b1};
			rx_q      <= 8'd0;
			ack_q     <= 1'b0;
			ackp_q    <= 1'b0;
		end else if (step_en) begin
			cmd_q     <= cmd_d;
			busy_q    <= busy_d;
			step_q    <= step_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			lines_q   <= lines_d;
			rx_q      <= rx_d;
			ack_q     <= ack_d;
			ackp_q    <= ackp_d;
		end
	end

	// The bit counter never runs past a whole byte.
	`ASSERT_ALWAYS(a_bit_range, clk, arst_n, bit_idx_q <= i2cbm_pkg::BIT_COUNT)
	// A running command always sits in one of its three phases.
	`ASSERT_IMPLIES(a_step_range, clk, arst_n, busy_q, step_q <= i2cbm_pkg::PHASE_LAST)
	// The phase timer is parked at zero while idle.
	`ASSERT_IMPLIES(a_idle_tick, clk, arst_n, !busy_q, tick_q == 8'd0)
	// Stop is a single phase and never touches the bit counter.
	`ASSERT_IMPLIES(a_stop_shape, clk, arst_n, busy_q && (cmd_q == i2cbm_pkg::CMD_STOP),
		(step_q == 3'd0) && (bit_idx_q == 4'd0))

endmodule

/* rtl/i2cbm_out_stage.sv */
`timescale 1ns / 1ps

module i2cbm_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  i2cbm_pkg::res_t   res_d,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output i2cbm_pkg::res_t   res_s2
);

	// A new word may land when the register is empty or being drained.
	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

endmodule
